// File: design/blba_pkg.sv
// Package for the battery level block averager: widths, register indexes,
// payload structs and the back-end state type. No dependencies.
`timescale 1ns / 1ps

package blba_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 10;
    localparam int MV_W        = 12;
    localparam int PCT_W       = 7;
    localparam int SUM_W       = SAMPLE_BITS + COUNT_BITS;
    localparam int PROD_W      = MV_W + COUNT_BITS;
    localparam int NUM_W       = PROD_W + SAMPLE_BITS;
    localparam int REM_W       = NUM_W + PCT_W;
    localparam int K_W         = 3;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [MV_W-1:0]  MV_FULL   = MV_W'(3600);
    localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_CAP   = PCT_W'(99);
    localparam logic [PCT_W-1:0] PCT_ZERO  = PCT_W'(0);
    localparam logic [K_W-1:0]   K_FIRST   = K_W'(PCT_W - 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [1:0] REG_BLOCK_SAMPLES = 2'd0;
    localparam logic [1:0] REG_CUTOFF_MV     = 2'd1;
    localparam logic [1:0] REG_NOMINAL_MV    = 2'd2;

    localparam logic [COUNT_BITS-1:0] BLOCK_SAMPLES_RST = COUNT_BITS'(16);
    localparam logic [MV_W-1:0]       CUTOFF_MV_RST     = MV_W'(2200);
    localparam logic [MV_W-1:0]       NOMINAL_MV_RST    = MV_W'(3000);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] batt_code;
        logic [SAMPLE_BITS-1:0] supply_code;
    } t_in_item;

    typedef struct packed {
        logic [MV_W-1:0]  batt_mv;
        logic [MV_W-1:0]  supply_mv;
        logic [PCT_W-1:0] batt_percent;
        logic             supply_good;
        logic             block_done;
        logic             report_valid;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] batt_code;
        logic [MV_W-1:0]        batt_mv;
        logic [MV_W-1:0]        supply_mv;
    } t_q_entry;

    typedef struct packed {
        logic [COUNT_BITS-1:0] block_samples;
        logic [MV_W-1:0]       cutoff_mv;
        logic [MV_W-1:0]       nominal_mv;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_SCALE,
        S_DIV,
        S_OUT
    } t_back_state;

endpackage

// File: design/blba_front.sv
// Front end: accepts sample beats, converts both codes to millivolts and
// holds them in a two-entry queue for the back end. Depends on blba_pkg.
`timescale 1ns / 1ps

module blba_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  blba_pkg::t_in_item  i_data,
    input  logic                i_q_pop,
    output logic                o_q_empty,
    output blba_pkg::t_q_entry  o_q_head
);
    import blba_pkg::*;

    t_q_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 push_ok;
    logic                 pop_ok;
    logic [SAMPLE_BITS+MV_W-1:0] batt_prod;
    logic [SAMPLE_BITS+MV_W-1:0] supply_prod;
    t_q_entry             new_entry;

    assign full      = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_q_empty = (r_cnt == '0);
    assign push_ok   = push && !full;
    assign pop_ok    = i_q_pop && !o_q_empty;
    assign o_q_head  = r_mem[r_rptr];

    // mV = code * 3600 / 2^SAMPLE_BITS, truncated
    assign batt_prod   = (SAMPLE_BITS+MV_W)'(i_data.batt_code) * (SAMPLE_BITS+MV_W)'(MV_FULL);
    assign supply_prod = (SAMPLE_BITS+MV_W)'(i_data.supply_code) * (SAMPLE_BITS+MV_W)'(MV_FULL);

    always_comb begin
        new_entry.batt_code = i_data.batt_code;
        new_entry.batt_mv   = batt_prod[SAMPLE_BITS +: MV_W];
        new_entry.supply_mv = supply_prod[SAMPLE_BITS +: MV_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(push_ok) - Q_CNT_W'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= new_entry;
        end
    end

endmodule

// File: design/blba_back.sv
// Back end: block accumulator, exact end-of-block compare, seven-step
// restoring divider for the percentage, and the result register. Depends on blba_pkg.
`timescale 1ns / 1ps

module blba_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  blba_pkg::t_cfg      i_cfg,
    input  logic                i_q_empty,
    input  blba_pkg::t_q_entry  i_q_head,
    output logic                o_q_pop,
    output logic                empty,
    input  logic                pop,
    output blba_pkg::t_out_item o_data
);
    import blba_pkg::*;

    t_back_state            r_state;
    t_back_state            n_state;
    logic [COUNT_BITS-1:0]  r_count;
    logic [SUM_W-1:0]       r_sum;
    logic                   r_startup;
    logic                   r_ok;
    logic [PCT_W-1:0]       r_pct;
    t_q_entry               r_entry;
    logic [NUM_W-1:0]       r_num;
    logic [PROD_W-1:0]      r_cn;
    logic [PROD_W-1:0]      r_nn;
    logic [PROD_W-1:0]      r_dn;
    logic [REM_W-1:0]       r_rem;
    logic [NUM_W-1:0]       r_div;
    logic [PCT_W-1:0]       r_quo;
    logic [K_W-1:0]         r_k;
    t_out_item              r_res;

    logic [COUNT_BITS-1:0]  blk_n;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [SUM_W-1:0]       sum_add;
    logic                   close;
    logic [NUM_W-1:0]       cut_s;
    logic [NUM_W-1:0]       nom_s;
    logic                   gt_cut;
    logic                   ge_nom;
    logic [REM_W-1:0]       div_sh;
    logic [REM_W:0]         trial;
    logic                   trial_ok;
    logic [PCT_W-1:0]       quo_next;
    logic                   fin;
    logic [PCT_W-1:0]       fin_pct;
    logic                   fin_ok;

    assign blk_n   = (i_cfg.block_samples == '0) ? COUNT_BITS'(1) : i_cfg.block_samples;
    assign cnt_inc = r_count + COUNT_BITS'(1);
    assign sum_add = r_sum + SUM_W'(i_q_head.batt_code);
    assign close   = (cnt_inc >= blk_n) || (cnt_inc == '0);

    assign cut_s  = {r_cn, {SAMPLE_BITS{1'b0}}};
    assign nom_s  = {r_nn, {SAMPLE_BITS{1'b0}}};
    assign gt_cut = (r_num > cut_s);
    assign ge_nom = (r_num >= nom_s);

    assign div_sh   = REM_W'(r_div) << r_k;
    assign trial    = {1'b0, r_rem} - {1'b0, div_sh};
    assign trial_ok = !trial[REM_W];
    assign quo_next = trial_ok ? (r_quo | (PCT_W'(1) << r_k)) : r_quo;

    always_comb begin
        fin     = 1'b0;
        fin_pct = PCT_ZERO;
        fin_ok  = r_ok;
        unique case (r_state)
            S_CMP: begin
                fin_ok = gt_cut;
                if (ge_nom) begin
                    fin     = 1'b1;
                    fin_pct = PCT_FULL;
                end else if (!gt_cut) begin
                    fin     = 1'b1;
                    fin_pct = PCT_ZERO;
                end
            end
            S_DIV: begin
                fin     = (r_k == '0);
                fin_pct = (quo_next >= PCT_FULL) ? PCT_CAP : quo_next;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = close ? S_MUL : S_OUT;
                end
            end
            S_MUL:   n_state = S_CMP;
            S_CMP:   n_state = fin ? S_OUT : S_SCALE;
            S_SCALE: n_state = S_DIV;
            S_DIV:   n_state = fin ? S_OUT : S_DIV;
            S_OUT: begin
                if (pop) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_state == S_IDLE) && !i_q_empty;
        empty   = (r_state != S_OUT);
        o_data  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_startup <= 1'b1;
            r_ok      <= 1'b0;
            r_pct     <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_sum   <= sum_add;
                r_count <= cnt_inc;
            end
            if (r_state == S_CMP) begin
                r_ok <= gt_cut;
            end
            if (fin) begin
                r_pct     <= fin_pct;
                r_startup <= 1'b0;
                r_sum     <= '0;
                r_count   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    r_entry            <= i_q_head;
                    r_res.batt_mv      <= i_q_head.batt_mv;
                    r_res.supply_mv    <= i_q_head.supply_mv;
                    r_res.batt_percent <= r_pct;
                    r_res.supply_good  <= r_ok;
                    r_res.block_done   <= 1'b0;
                    r_res.report_valid <= !r_startup;
                end
            end
            S_MUL: begin
                r_num <= NUM_W'(r_sum) * NUM_W'(MV_FULL);
                r_cn  <= PROD_W'(i_cfg.cutoff_mv) * PROD_W'(blk_n);
                r_nn  <= PROD_W'(i_cfg.nominal_mv) * PROD_W'(blk_n);
                r_dn  <= PROD_W'(i_cfg.nominal_mv - i_cfg.cutoff_mv) * PROD_W'(blk_n);
            end
            S_CMP: begin
                r_rem <= REM_W'(r_num - cut_s);
            end
            S_SCALE: begin
                r_rem <= REM_W'(r_rem[NUM_W-1:0]) * REM_W'(PCT_SCALE);
                r_div <= {r_dn, {SAMPLE_BITS{1'b0}}};
                r_quo <= '0;
                r_k   <= K_FIRST;
            end
            S_DIV: begin
                if (trial_ok) begin
                    r_rem <= trial[REM_W-1:0];
                end
                r_quo <= quo_next;
                r_k   <= r_k - K_W'(1);
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
        if (fin) begin
            r_res.batt_mv      <= r_entry.batt_mv;
            r_res.supply_mv    <= r_entry.supply_mv;
            r_res.batt_percent <= fin_pct;
            r_res.supply_good  <= fin_ok;
            r_res.block_done   <= 1'b1;
            r_res.report_valid <= 1'b1;
        end
    end

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop) |=> empty)
        else $error("result beat delivered twice");

    a_done_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.block_done) |-> o_data.report_valid)
        else $error("closed block without report_valid");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data.batt_percent <= PCT_FULL))
        else $error("percent above full");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_quo < PCT_FULL))
        else $error("divider quotient out of range");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_OUT || r_state == S_MUL))
        else $error("queue beat taken outside idle");

endmodule

// File: design/battery_level_block_averager.sv
// Top level of the battery level block averager: configuration registers
// on the APB-style port, front end and back end. Depends on blba_pkg, blba_front, blba_back.
`timescale 1ns / 1ps

// Each beat pushed is one conversion pair and gives exactly one result beat
// with both voltages in mV and the level from the last closed block;
// report_valid rises with the first closed block. A sample that does not
// close a block goes from idle straight to the result state in the back end. A
// block-closing sample passes through the multiply and compare states, and, when the
// block average lies between cut-off and nominal, also through the scale step and the
// seven-step restoring divider that form the percentage. The front queue holds two
// beats, so pushes continue while a result waits to be popped. Registers: 0x0
// block_samples, 0x4 cutoff_mv, 0x8 nominal_mv; write them only while no beat is in flight.

module battery_level_block_averager (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blba_pkg::ADDR_W-1:0]   paddr,
    input  logic [blba_pkg::DATA_W-1:0]   pwdata,
    output logic [blba_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  blba_pkg::t_in_item            i_data,
    output logic                          empty,
    input  logic                          pop,
    output blba_pkg::t_out_item           o_data
);
    import blba_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;
    logic       q_pop;
    logic       q_empty;
    t_q_entry   q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_samples <= BLOCK_SAMPLES_RST;
            r_cfg.cutoff_mv     <= CUTOFF_MV_RST;
            r_cfg.nominal_mv    <= NOMINAL_MV_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BLOCK_SAMPLES: r_cfg.block_samples <= pwdata[COUNT_BITS-1:0];
                REG_CUTOFF_MV:     r_cfg.cutoff_mv     <= pwdata[MV_W-1:0];
                REG_NOMINAL_MV:    r_cfg.nominal_mv    <= pwdata[MV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BLOCK_SAMPLES: prdata = DATA_W'(r_cfg.block_samples);
            REG_CUTOFF_MV:     prdata = DATA_W'(r_cfg.cutoff_mv);
            REG_NOMINAL_MV:    prdata = DATA_W'(r_cfg.nominal_mv);
            default:           prdata = '0;
        endcase
    end

    blba_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_data    (i_data),
        .i_q_pop   (q_pop),
        .o_q_empty (q_empty),
        .o_q_head  (q_head)
    );

    blba_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_data    (o_data)
    );

endmodule
